/* hdl/context_slot_allocator_macros.svh */
// Assertion macros shared by the slot allocator RTL.
`ifndef CONTEXT_SLOT_ALLOCATOR_MACROS_SVH
`define CONTEXT_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/csa_pkg.sv */
// Types, constants and helper functions of the context slot allocator.
`default_nettype none

package csa_pkg;

   // Slot array geometry
   localparam int SLOT_COUNT = 320;
   localparam int SLOT_BYTES = 64;

   // Field widths
   localparam int ADDR_W      = 32;
   localparam int FIELD_IDX_W = 9;
   localparam int STATUS_W    = 3;

   // Bitmap memory organization: one word of in-use bits per row
   localparam int WORD_W    = 32;
   localparam int BIT_W     = 5;
   localparam int ROW_COUNT = (SLOT_COUNT + WORD_W - 1) / WORD_W;
   localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int SIDX_W    = ROW_W + BIT_W;

   // Bits of the last row that lie past the final slot read as used
   localparam int LAST_USED = SLOT_COUNT - (ROW_COUNT - 1) * WORD_W;
   localparam logic [WORD_W-1:0] LAST_PAD =
      WORD_W'(~((64'd1 << LAST_USED) - 64'd1));

   // Release decode: offset range and reciprocal for the slot divide
   localparam longint SPAN        = longint'(SLOT_COUNT) * longint'(SLOT_BYTES);
   localparam int     OFF_W       = $clog2(SPAN + 1);
   localparam int     BYTES_LOG   = $clog2(SLOT_BYTES);
   localparam int     RECIP_SHIFT = OFF_W + BYTES_LOG;
   localparam longint RECIP_MULT  =
      ((longint'(1) <<< RECIP_SHIFT) + longint'(SLOT_BYTES) - 1) / longint'(SLOT_BYTES);
   localparam int     PROD_W      = RECIP_SHIFT + SIDX_W;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_SET_UP  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ALL_USED    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BELOW_BASE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_A_SLOT  = 3'd4;

   // Request actions
   localparam logic ACTION_ALLOCATE = 1'b0;
   localparam logic ACTION_RELEASE  = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] slot_address_in;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]      slot_address_out;
      logic [FIELD_IDX_W-1:0] slot_index;
      logic [STATUS_W-1:0]    status;
   } rsp_type;

   // Bitmap write port
   typedef struct packed {
      logic              en;
      logic [ROW_W-1:0]  row;
      logic [WORD_W-1:0] word;
   } wr_type;

   // Decoded release address
   typedef struct packed {
      logic              below_base;
      logic              not_slot;
      logic [SIDX_W-1:0] idx;
   } rel_info_type;

   // Padding mask of a row: set where no slot exists
   function automatic logic [WORD_W-1:0] row_pad(input logic [ROW_W-1:0] row);
      return (row == ROW_W'(ROW_COUNT - 1)) ? LAST_PAD : '0;
   endfunction

   // Low bits of a slot index as carried in the result
   function automatic logic [FIELD_IDX_W-1:0] to_field_index(input logic [SIDX_W-1:0] idx);
      logic [SIDX_W+FIELD_IDX_W-1:0] wide;
      wide = {{FIELD_IDX_W{1'b0}}, idx};
      return wide[FIELD_IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/context_slot_allocator.sv */
// Top level of the context slot allocator: control, free-row summary, response.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start=1 and busy=0
//   result    rsp_valid, rsp_data            one-cycle strobe, always taken
//   csr       csr_valid, csr_ready, csr_data written when valid=1 and ready=1
//
// An allocate goes from idle to the modify state, a release via the check state:
// the bitmap memory's registered read sets the pace, and a release registers
// its slot divide first. The result strobes in the cycle after the work finishes;
// a new request can be taken in that same cycle. Reset clears the base, the per-row
// valid bits and the full-row summary at once, so no clearing pass is needed.
`default_nettype none
`include "context_slot_allocator_macros.svh"

module context_slot_allocator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire csa_pkg::req_type            req_data,
   output logic                             rsp_valid,
   output csa_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [csa_pkg::ADDR_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_CHECK  = 3'b010,
      S_MODIFY = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [csa_pkg::ADDR_W-1:0]    base_ff;
   logic                          is_release_ff, is_release_in;
   logic                          none_free_ff, none_free_in;
   logic [csa_pkg::ROW_W-1:0]     alloc_row_ff, alloc_row_in;
   logic [csa_pkg::ROW_COUNT-1:0] row_full_ff, row_full_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   csa_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          accept;
   logic [csa_pkg::ROW_W-1:0]     free_row;
   logic [csa_pkg::ROW_W-1:0]     rd_row;
   logic [csa_pkg::WORD_W-1:0]    rd_word;
   logic [csa_pkg::WORD_W-1:0]    word_eff;
   logic [csa_pkg::BIT_W-1:0]     alloc_bit;
   logic [csa_pkg::SIDX_W-1:0]    alloc_idx;
   csa_pkg::wr_type               wr;
   csa_pkg::rel_info_type         rel;

   assign accept    = start & ~busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Hold the array base
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         base_ff <= csr_data;
      end
   end

   // Lowest row with a free slot
   always_comb begin
      free_row = '0;
      for (int r = csa_pkg::ROW_COUNT - 1; r >= 0; r--) begin
         if (!row_full_ff[r]) begin
            free_row = csa_pkg::ROW_W'(r);
         end
      end
   end

   // Read the candidate row on accept, the release row during the check
   assign rd_row = (state_ff == S_IDLE) ? free_row : rel.idx[csa_pkg::SIDX_W-1:csa_pkg::BIT_W];

   csa_release_decode u_decode (
      .clock (clock),
      .load  (accept && (req_data.action == csa_pkg::ACTION_RELEASE)),
      .base  (base_ff),
      .addr  (req_data.slot_address_in),
      .info  (rel)
   );

   csa_slot_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_row  (rd_row),
      .rd_word (rd_word),
      .wr      (wr)
   );

   // Lowest free bit of the allocated row
   assign word_eff = rd_word | csa_pkg::row_pad(alloc_row_ff);
   always_comb begin
      alloc_bit = '0;
      for (int b = csa_pkg::WORD_W - 1; b >= 0; b--) begin
         if (!word_eff[b]) begin
            alloc_bit = csa_pkg::BIT_W'(b);
         end
      end
   end
   assign alloc_idx = {alloc_row_ff, alloc_bit};

   // Sequence the request, modify the row and build the response
   always_comb begin
      state_in      = state_ff;
      is_release_in = is_release_ff;
      none_free_in  = none_free_ff;
      alloc_row_in  = alloc_row_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr            = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               is_release_in = (req_data.action == csa_pkg::ACTION_RELEASE);
               none_free_in  = &row_full_ff;
               alloc_row_in  = free_row;
               state_in      = is_release_in ? S_CHECK : S_MODIFY;
            end
         end
         S_CHECK: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            state_in                = S_IDLE;
            rsp_valid_in            = 1'b1;
            rsp_in.slot_address_out = '0;
            rsp_in.slot_index       = '0;
            rsp_in.status           = csa_pkg::STATUS_OK;
            if (base_ff == '0) begin
               rsp_in.status = csa_pkg::STATUS_NOT_SET_UP;
            end else if (!is_release_ff) begin
               if (none_free_ff) begin
                  rsp_in.status = csa_pkg::STATUS_ALL_USED;
               end else begin
                  wr.en   = 1'b1;
                  wr.row  = alloc_row_ff;
                  wr.word = rd_word | (csa_pkg::WORD_W'(1) << alloc_bit);
                  rsp_in.slot_address_out = base_ff +
                     csa_pkg::ADDR_W'(alloc_idx) * csa_pkg::ADDR_W'(csa_pkg::SLOT_BYTES);
                  rsp_in.slot_index = csa_pkg::to_field_index(alloc_idx);
               end
            end else if (rel.below_base) begin
               rsp_in.status = csa_pkg::STATUS_BELOW_BASE;
            end else if (rel.not_slot) begin
               rsp_in.status = csa_pkg::STATUS_NOT_A_SLOT;
            end else begin
               wr.en   = 1'b1;
               wr.row  = rel.idx[csa_pkg::SIDX_W-1:csa_pkg::BIT_W];
               wr.word = rd_word &
                  ~(csa_pkg::WORD_W'(1) << rel.idx[csa_pkg::BIT_W-1:0]);
               rsp_in.slot_index = csa_pkg::to_field_index(rel.idx);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Track rows with no free slot as they are written back
   always_comb begin
      row_full_in = row_full_ff;
      if (wr.en) begin
         row_full_in[wr.row] = &(wr.word | csa_pkg::row_pad(wr.row));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_full_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_full_ff  <= row_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_release_ff <= is_release_in;
      none_free_ff  <= none_free_in;
      alloc_row_ff  <= alloc_row_in;
      rsp_ff        <= rsp_in;
   end

   `CSA_ASSERT_NEXT(a_rsp_after_modify, clock, reset, state_ff == S_MODIFY, rsp_valid_ff, "no response after modify")
   `CSA_ASSERT_SAME(a_rsp_only_after_modify, clock, reset, rsp_valid_ff, $past(state_ff == S_MODIFY), "response without modify")
   `CSA_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy, "not busy after accept")
   `CSA_ASSERT_SAME(a_failure_zero, clock, reset, rsp_valid_ff && (rsp_ff.status != csa_pkg::STATUS_OK), (rsp_ff.slot_address_out == '0) && (rsp_ff.slot_index == '0), "failed result carries address or index")
   `CSA_ASSERT_SAME(a_summary_matches_row, clock, reset, (state_ff == S_MODIFY) && !is_release_ff && !none_free_ff, ~&word_eff, "row marked free has no free slot")

endmodule

`default_nettype wire

/* hdl/csa_slot_ram.sv */
// In-use bitmap memory: one word per row, registered read, per-row valid bits.
`default_nettype none

module csa_slot_ram (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [csa_pkg::ROW_W-1:0]   rd_row,
   output logic      [csa_pkg::WORD_W-1:0]  rd_word,
   input  wire csa_pkg::wr_type             wr
);

   logic [csa_pkg::WORD_W-1:0]    mem [csa_pkg::ROW_COUNT];
   logic [csa_pkg::WORD_W-1:0]    rd_data_ff;
   logic                          rd_valid_ff;
   logic [csa_pkg::ROW_COUNT-1:0] row_valid_ff;
   logic [csa_pkg::ROW_COUNT-1:0] row_valid_in;

   // Write and read the array, old data on a same-row access
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row] <= wr.word;
      end
      rd_data_ff <= mem[rd_row];
   end

   // Mark a row written; rows never written read as all free
   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr.en) begin
         row_valid_in[wr.row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= row_valid_ff[rd_row];
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* hdl/csa_release_decode.sv */
// Release address decode: offset check, slot divide by reciprocal, alignment check.
`default_nettype none

module csa_release_decode (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire logic [csa_pkg::ADDR_W-1:0]  base,
   input  wire logic [csa_pkg::ADDR_W-1:0]  addr,
   output csa_pkg::rel_info_type            info
);

   logic [csa_pkg::ADDR_W-1:0] offset;
   logic [csa_pkg::PROD_W-1:0] prod;
   logic [csa_pkg::OFF_W-1:0]  rem;

   logic                       below_ff;
   logic                       range_bad_ff;
   logic [csa_pkg::OFF_W-1:0]  off_ff;
   logic [csa_pkg::SIDX_W-1:0] quot_ff;

   // Offset from the base and the quotient estimate by reciprocal multiply
   assign offset = addr - base;
   assign prod   = csa_pkg::PROD_W'(offset[csa_pkg::OFF_W-1:0]) *
                   csa_pkg::PROD_W'(csa_pkg::RECIP_MULT);

   // Capture the first stage when a release request is accepted
   always_ff @(posedge clock) begin
      if (load) begin
         below_ff     <= addr < base;
         range_bad_ff <= offset >= csa_pkg::ADDR_W'(csa_pkg::SPAN);
         off_ff       <= offset[csa_pkg::OFF_W-1:0];
         quot_ff      <= prod[csa_pkg::RECIP_SHIFT +: csa_pkg::SIDX_W];
      end
   end

   // Remainder after the slot divide; nonzero means misaligned
   assign rem = off_ff - csa_pkg::OFF_W'(csa_pkg::OFF_W'(quot_ff) *
                                         csa_pkg::OFF_W'(csa_pkg::SLOT_BYTES));

   assign info.below_base = below_ff;
   assign info.not_slot   = range_bad_ff | (rem != '0);
   assign info.idx        = quot_ff;

endmodule

`default_nettype wire
